// ----- design/vector_l2_normalize_core_macros.svh -----
// ----------------------------------------------------------------------------
// vector_l2_normalize_core assertion macros
// concurrent check wrappers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef VECTOR_L2_NORMALIZE_CORE_MACROS_SVH
`define VECTOR_L2_NORMALIZE_CORE_MACROS_SVH

`ifndef SYNTH

// same-cycle implication check
`define VL2N_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("vl2n same-cycle check failed");

// next-cycle implication check
`define VL2N_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("vl2n next-cycle check failed");

`else

`define VL2N_ASSERT_IMPLIES(label, ante, cons)
`define VL2N_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/vl2n_pkg.sv -----
// ----------------------------------------------------------------------------
// vl2n_pkg
// shared widths, constants and sequencer states of the l2 normalize core
// ----------------------------------------------------------------------------
package vl2n_pkg;

    // element and result width
    localparam int ELEM_W     = 16;
    // one square of a 16-bit signed value fits in 31 bits
    localparam int SQ_W       = 31;
    // square sum is scaled by 2^16 before the root
    localparam int ROOT_SHIFT = 16;
    // initial remainder for the quotient is mag * 2^8
    localparam int SAT_SHIFT  = 8;
    // quotient bits below the saturation limit
    localparam int QBITS      = 15;
    // saturation magnitude, q1.15 max
    localparam logic [QBITS-1:0] SAT_MAG = {QBITS{1'b1}};

    // sequencer states
    typedef enum logic [3:0] {
        ST_LOAD,
        ST_FLUSH,
        ST_PREP,
        ST_ROOT,
        ST_READ,
        ST_FETCH,
        ST_SAT,
        ST_DIV,
        ST_EMIT
    } vl2n_state_t;

endpackage

// ----- design/vl2n_in_if.sv -----
// ----------------------------------------------------------------------------
// vl2n_in_if
// element channel: valid/ready with one vector element per transfer
// ----------------------------------------------------------------------------
interface vl2n_in_if
    import vl2n_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] element;
    logic                     last_element;

    modport source (output valid, output element, output last_element, input ready);
    modport sink   (input valid, input element, input last_element, output ready);

endinterface

// ----- design/vl2n_out_if.sv -----
// ----------------------------------------------------------------------------
// vl2n_out_if
// result channel: valid/ready with one normalized value and flags per transfer
// ----------------------------------------------------------------------------
interface vl2n_out_if
    import vl2n_pkg::*;
();

    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] normalized_value;
    logic                     final_result;
    logic                     zero_norm;
    logic                     length_overflow;

    modport source (
        output valid, output normalized_value, output final_result,
        output zero_norm, output length_overflow, input ready
    );
    modport sink (
        input valid, input normalized_value, input final_result,
        input zero_norm, input length_overflow, output ready
    );

endinterface

// ----- design/vector_l2_normalize_core.sv -----
// ----------------------------------------------------------------------------
// vector_l2_normalize_core
// l2 normalization of a vector of signed 16-bit elements into q1.15 results
// ----------------------------------------------------------------------------
// channel   dir  modport  payload
// samples   in   sink     element, last_element
// results   out  source   normalized_value, final_result, zero_norm,
//                         length_overflow
//
// loading takes one element per cycle; the last element is followed by square
// flush and setup, then RW root steps (27 at MAX_LEN = 64), one per cycle;
// a zero sum skips the root; each result is read, fetched, checked for
// saturation, passes 15 quotient steps on the shared compare/subtract unit and
// is output; saturation skips the quotient steps, a zero norm also the check
// samples.ready is low from the last element until the final result transfers
// a stall on results holds the output register; reset is asynchronous and
// clears the sequencer, element count, overflow flag and sum
// ----------------------------------------------------------------------------
`include "vector_l2_normalize_core_macros.svh"

module vector_l2_normalize_core
    import vl2n_pkg::*;
#(
    parameter int MAX_LEN = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    vl2n_in_if.sink      samples,
    vl2n_out_if.source   results
);

    localparam int AW  = $clog2(MAX_LEN);
    localparam int CW  = $clog2(MAX_LEN + 1);
    localparam int SW  = SQ_W + $clog2(MAX_LEN);
    localparam int RW  = (SW + ROOT_SHIFT + 1) / 2;
    localparam int NW  = 2 * RW;
    localparam int UW  = RW + 2;
    localparam int STW = $clog2(RW + 1);

    vl2n_state_t       state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic              ovf_reg, ovf_next;
    logic [SW-1:0]     sum_reg, sum_next;
    logic [SQ_W-1:0]   sq_reg;
    logic              sq_vld_reg, sq_vld_next;
    logic              zero_reg, zero_next;
    logic [NW-1:0]     nsh_reg, nsh_next;
    logic [UW-1:0]     rem_reg, rem_next;
    logic [RW-1:0]     root_reg, root_next;
    logic [STW-1:0]    step_reg, step_next;
    logic [AW-1:0]     idx_reg, idx_next;
    logic              neg_reg, neg_next;
    logic [QBITS-1:0]  quo_reg, quo_next;
    logic [ELEM_W-1:0] val_reg, val_next;
    logic              fin_reg, fin_next;

    logic              in_xfer;
    logic              out_xfer;
    logic              room;
    logic [ELEM_W:0]   in_ext;
    logic [ELEM_W:0]   in_mag;
    logic [2*ELEM_W+1:0] in_sq;
    logic [ELEM_W-1:0] rdata;
    logic [ELEM_W:0]   rd_ext;
    logic [ELEM_W:0]   rd_mag;
    logic [QBITS-1:0]  quo_step;
    logic [UW-1:0]     unit_a, unit_b, unit_diff;
    logic              unit_ge;

    // handshakes
    assign samples.ready = (state_reg == ST_LOAD);
    assign in_xfer       = samples.valid && samples.ready;
    assign results.valid = (state_reg == ST_EMIT);
    assign out_xfer      = results.valid && results.ready;
    assign room          = (count_reg != CW'(MAX_LEN));

    // result payload
    assign results.normalized_value = val_reg;
    assign results.final_result     = fin_reg;
    assign results.zero_norm        = zero_reg;
    assign results.length_overflow  = ovf_reg;

    // magnitude and square of the incoming element
    assign in_ext = {samples.element[ELEM_W-1], samples.element};
    assign in_mag = in_ext[ELEM_W] ? ((ELEM_W+1)'(0) - in_ext) : in_ext;
    assign in_sq  = in_mag * in_mag;

    // magnitude of the buffered element
    assign rd_ext = {rdata[ELEM_W-1], rdata};
    assign rd_mag = rd_ext[ELEM_W] ? ((ELEM_W+1)'(0) - rd_ext) : rd_ext;

    // quotient with the current step's bit shifted in
    assign quo_step = {quo_reg[QBITS-2:0], unit_ge};

    // element buffer
    vl2n_elem_mem #(
        .DEPTH (MAX_LEN),
        .AW    (AW)
    ) u_mem (
        .clk   (clk),
        .we    (in_xfer && room),
        .waddr (count_reg[AW-1:0]),
        .wdata (samples.element),
        .raddr (idx_reg),
        .rdata (rdata)
    );

    // shared compare and subtract unit
    vl2n_cmp_sub #(
        .W (UW)
    ) u_unit (
        .a    (unit_a),
        .b    (unit_b),
        .diff (unit_diff),
        .ge   (unit_ge)
    );

    // square register, holds the square of the accepted element in the next cycle
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            sq_reg <= in_sq[SQ_W-1:0];
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_LOAD;
            count_reg  <= '0;
            ovf_reg    <= 1'b0;
            sum_reg    <= '0;
            sq_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            ovf_reg    <= ovf_next;
            sum_reg    <= sum_next;
            sq_vld_reg <= sq_vld_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        zero_reg <= zero_next;
        nsh_reg  <= nsh_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        step_reg <= step_next;
        idx_reg  <= idx_next;
        neg_reg  <= neg_next;
        quo_reg  <= quo_next;
        val_reg  <= val_next;
        fin_reg  <= fin_next;
    end

    // sequencer: next state and datapath control
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        ovf_next    = ovf_reg;
        sum_next    = sum_reg;
        sq_vld_next = 1'b0;
        zero_next   = zero_reg;
        nsh_next    = nsh_reg;
        rem_next    = rem_reg;
        root_next   = root_reg;
        step_next   = step_reg;
        idx_next    = idx_reg;
        neg_next    = neg_reg;
        quo_next    = quo_reg;
        val_next    = val_reg;
        fin_next    = fin_reg;
        unit_a      = '0;
        unit_b      = '0;

        // accumulate the pending square
        if (sq_vld_reg)
        begin
            sum_next = sum_reg + SW'(sq_reg);
        end

        case (state_reg)
            ST_LOAD:
            begin
                if (in_xfer)
                begin
                    if (room)
                    begin
                        count_next  = count_reg + CW'(1);
                        sq_vld_next = 1'b1;
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (samples.last_element)
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end

            ST_FLUSH:
            begin
                state_next = ST_PREP;
            end

            // scale the sum by 2^16 and start the root, or skip it when the sum is zero
            ST_PREP:
            begin
                zero_next = (sum_reg == '0);
                nsh_next  = NW'({sum_reg, {ROOT_SHIFT{1'b0}}});
                rem_next  = '0;
                root_next = '0;
                step_next = STW'(RW);
                idx_next  = '0;
                if (sum_reg == '0)
                begin
                    state_next = ST_READ;
                end
                else
                begin
                    state_next = ST_ROOT;
                end
            end

            // one root digit per cycle
            ST_ROOT:
            begin
                unit_a   = {rem_reg[RW-1:0], nsh_reg[NW-1 -: 2]};
                unit_b   = {root_reg, 2'b01};
                nsh_next = {nsh_reg[NW-3:0], 2'b00};
                if (unit_ge)
                begin
                    rem_next  = unit_diff;
                    root_next = {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = unit_a;
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
                step_next = step_reg - STW'(1);
                if (step_reg == STW'(1))
                begin
                    state_next = ST_READ;
                end
            end

            ST_READ:
            begin
                state_next = ST_FETCH;
            end

            // buffered element is in the read register
            ST_FETCH:
            begin
                neg_next = rdata[ELEM_W-1];
                rem_next = UW'({rd_mag, {SAT_SHIFT{1'b0}}});
                quo_next = '0;
                fin_next = ((CW'(idx_reg) + CW'(1)) == count_reg);
                if (zero_reg)
                begin
                    val_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    state_next = ST_SAT;
                end
            end

            // quotient of 2^15 or more saturates
            ST_SAT:
            begin
                unit_a = rem_reg;
                unit_b = UW'(root_reg);
                if (unit_ge)
                begin
                    val_next   = neg_reg ? (ELEM_W'(0) - ELEM_W'(SAT_MAG))
                                         : ELEM_W'(SAT_MAG);
                    state_next = ST_EMIT;
                end
                else
                begin
                    step_next  = STW'(QBITS);
                    state_next = ST_DIV;
                end
            end

            // one quotient bit per cycle
            ST_DIV:
            begin
                unit_a   = {rem_reg[UW-2:0], 1'b0};
                unit_b   = UW'(root_reg);
                rem_next = unit_ge ? unit_diff : unit_a;
                quo_next = quo_step;
                step_next = step_reg - STW'(1);
                if (step_reg == STW'(1))
                begin
                    val_next   = neg_reg ? (ELEM_W'(0) - ELEM_W'(quo_step))
                                         : ELEM_W'(quo_step);
                    state_next = ST_EMIT;
                end
            end

            ST_EMIT:
            begin
                if (out_xfer)
                begin
                    if (fin_reg)
                    begin
                        count_next = '0;
                        ovf_next   = 1'b0;
                        sum_next   = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = ST_READ;
                    end
                end
            end

            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // checks
    `VL2N_ASSERT_IMPLIES(a_no_overlap, samples.ready, !results.valid)
    `VL2N_ASSERT_IMPLIES(a_zero_value, results.valid && results.zero_norm, results.normalized_value == '0)
    `VL2N_ASSERT_IMPLIES(a_no_min_value, results.valid, results.normalized_value != 16'sh8000)
    `VL2N_ASSERT_NEXT(a_reload_after_final, out_xfer && results.final_result, samples.ready && (count_reg == '0))

endmodule

// ----- design/vl2n_cmp_sub.sv -----
// ----------------------------------------------------------------------------
// vl2n_cmp_sub
// shared compare and subtract unit for root, saturation and quotient steps
// ----------------------------------------------------------------------------
module vl2n_cmp_sub
    import vl2n_pkg::*;
#(
    parameter int W = 8
) (
    input  logic [W-1:0] a,
    input  logic [W-1:0] b,
    output logic [W-1:0] diff,
    output logic         ge
);

    logic [W:0] wide;

    // borrow out of the subtract is the less-than flag
    assign wide = {1'b0, a} - {1'b0, b};
    assign diff = wide[W-1:0];
    assign ge   = ~wide[W];

endmodule

// ----- design/vl2n_elem_mem.sv -----
// ----------------------------------------------------------------------------
// vl2n_elem_mem
// element buffer, one write port and one registered read port
// ----------------------------------------------------------------------------
module vl2n_elem_mem
    import vl2n_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  logic [ELEM_W-1:0] wdata,
    input  logic [AW-1:0]     raddr,
    output logic [ELEM_W-1:0] rdata
);

    logic [ELEM_W-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule
